@@ design/tdrs_pkg.sv @@
package tdrs_pkg;

    localparam int COORD_W = 16;
    localparam int DZ_W    = 15;
    localparam int MAG_W   = COORD_W + 1;
    localparam int SQ_W    = 2 * COORD_W;

    localparam logic [DZ_W-1:0] STICK_MAX = 15'h7FFF;

    typedef logic signed [COORD_W-1:0] coord_t;

    // Flags that ride alongside the x-lane divider
    typedef struct packed {
        logic in_dz;
        logic zero;
        logic neg;
        logic ovf;
    } lane_flags_t;

endpackage

@@ design/tdrs_sqrt.sv @@
module tdrs_sqrt #(
    parameter int RW = 32,
    parameter int TW = 1
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  logic [2*RW-1:0] rad,
    input  logic [TW-1:0]   in_tag,
    output logic            out_valid,
    output logic [RW-1:0]   root,
    output logic [TW-1:0]   out_tag
);

    logic              valid_reg [RW];
    logic [2*RW-1:0]   rad_reg   [RW];
    logic [RW:0]       rem_reg   [RW];
    logic [RW-1:0]     root_reg  [RW];
    logic [TW-1:0]     tag_reg   [RW];

    logic              valid_d [RW+1];
    logic [2*RW-1:0]   rad_d   [RW+1];
    logic [RW:0]       rem_d   [RW+1];
    logic [RW-1:0]     root_d  [RW+1];
    logic [TW-1:0]     tag_d   [RW+1];

    assign valid_d[0] = in_valid;
    assign rad_d[0]   = rad;
    assign rem_d[0]   = '0;
    assign root_d[0]  = '0;
    assign tag_d[0]   = in_tag;

    // One root bit per stage, two radicand bits consumed each time
    for (genvar k = 0; k < RW; k++) begin : g_stage
        logic [RW+2:0]   trial;
        logic [RW+2:0]   part;
        logic            ge;
        logic [RW:0]     rem_next;
        logic [RW-1:0]   root_next;

        always_comb
        begin
            part      = {rem_d[k], rad_d[k][2*RW-1 -: 2]};
            trial     = (RW+3)'({root_d[k], 2'b01});
            ge        = (part >= trial);
            rem_next  = ge ? (RW+1)'(part - trial) : (RW+1)'(part);
            root_next = (root_d[k] << 1) | RW'(ge);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k] <= valid_d[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_reg[k]  <= rad_d[k] << 2;
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                tag_reg[k]  <= tag_d[k];
            end
        end

        assign valid_d[k+1] = valid_reg[k];
        assign rad_d[k+1]   = rad_reg[k];
        assign rem_d[k+1]   = rem_reg[k];
        assign root_d[k+1]  = root_reg[k];
        assign tag_d[k+1]   = tag_reg[k];
    end

    assign out_valid = valid_d[RW];
    assign root      = root_d[RW];
    assign out_tag   = tag_d[RW];

endmodule

@@ design/tdrs_div.sv @@
module tdrs_div #(
    parameter int NW = 32,
    parameter int DW = 16,
    parameter int QW = 16,
    parameter int TW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    input  logic [TW-1:0] in_tag,
    output logic          out_valid,
    output logic [QW-1:0] quot,
    output logic [TW-1:0] out_tag
);

    // The caller guarantees num >> QW is below den, so QW stages suffice
    logic          valid_reg [QW];
    logic [NW-1:0] num_reg   [QW];
    logic [DW-1:0] den_reg   [QW];
    logic [DW-1:0] rem_reg   [QW];
    logic [QW-1:0] quot_reg  [QW];
    logic [TW-1:0] tag_reg   [QW];

    logic          valid_d [QW+1];
    logic [NW-1:0] num_d   [QW+1];
    logic [DW-1:0] den_d   [QW+1];
    logic [DW-1:0] rem_d   [QW+1];
    logic [QW-1:0] quot_d  [QW+1];
    logic [TW-1:0] tag_d   [QW+1];

    assign valid_d[0] = in_valid;
    assign num_d[0]   = num;
    assign den_d[0]   = den;
    assign rem_d[0]   = DW'(num >> QW);
    assign quot_d[0]  = '0;
    assign tag_d[0]   = in_tag;

    // Restoring division, one quotient bit per stage
    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [DW:0]   part;
        logic          ge;
        logic [DW-1:0] rem_next;
        logic [QW-1:0] quot_next;

        always_comb
        begin
            part      = {rem_d[k], num_d[k][QW-1-k]};
            ge        = (part >= {1'b0, den_d[k]});
            rem_next  = ge ? DW'(part - {1'b0, den_d[k]}) : DW'(part);
            quot_next = (quot_d[k] << 1) | QW'(ge);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k] <= valid_d[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                num_reg[k]  <= num_d[k];
                den_reg[k]  <= den_d[k];
                rem_reg[k]  <= rem_next;
                quot_reg[k] <= quot_next;
                tag_reg[k]  <= tag_d[k];
            end
        end

        assign valid_d[k+1] = valid_reg[k];
        assign num_d[k+1]   = num_reg[k];
        assign den_d[k+1]   = den_reg[k];
        assign rem_d[k+1]   = rem_reg[k];
        assign quot_d[k+1]  = quot_reg[k];
        assign tag_d[k+1]   = tag_reg[k];
    end

    assign out_valid = valid_d[QW];
    assign quot      = quot_d[QW];
    assign out_tag   = tag_d[QW];

endmodule

@@ design/thumbstick_radial_deadzone_scaler.sv @@
// Scaled radial deadzone for one thumbstick sample. Takes (x, y), forms the
// radius with RADIUS_FRACTION_BITS fraction bits, zeroes samples whose radius
// lies below deadzone_radius (tuser high), and otherwise rescales the clamped
// radius so that the deadzone edge maps to 0 and full deflection to 32767,
// keeping the direction. A fully pipelined square root and two levels of
// restoring dividers accept one sample every cycle, one root or quotient bit
// per stage. The whole pipeline holds while an output transfer is stalled.
// Write the deadzone only while the block is empty.
module thumbstick_radial_deadzone_scaler #(
    parameter int RADIUS_FRACTION_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // cfg_data: deadzone_radius
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [14:0] cfg_data,
    // s_tdata: [15:0] stick_x, [31:16] stick_y
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,
    // m_tdata: [15:0] scaled_x, [31:16] scaled_y
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,
    // m_tuser: [0] inside_deadzone
    output logic [0:0]  m_tuser
);

    import tdrs_pkg::*;

    localparam int F   = RADIUS_FRACTION_BITS;
    localparam int RW  = 16 + F;
    localparam int QW1 = 15 + F;
    localparam int N1W = 15 + RW;
    localparam int N2W = MAG_W + QW1;
    localparam int QW2 = 15;
    localparam logic [RW-1:0] MAXFIX = RW'(STICK_MAX) << F;

    logic en;

    logic [DZ_W-1:0]   dz_reg;
    logic [2*DZ_W-1:0] dz_sq_reg;

    // Stage registers
    logic              va_reg, vb_reg, vc_reg, vd_reg, ve_reg, vf_reg, vg_reg, vo_reg;
    coord_t            xa_reg, ya_reg, xb_reg, yb_reg, xc_reg, yc_reg;
    logic [SQ_W-1:0]   sqx_reg, sqy_reg, r2_reg;
    logic              inside_reg;
    logic [QW1-1:0]    diff_reg;
    logic [RW-1:0]     rd_reg, re_reg, rf_reg;
    coord_t            xd_reg, yd_reg, xe_reg, ye_reg, xf_reg, yf_reg;
    logic              ins_d_reg, zero_d_reg, ins_e_reg, zero_e_reg;
    logic              ins_f_reg, zero_f_reg;
    logic [N1W-1:0]    num1_reg;
    logic [N2W-1:0]    mulx_reg, muly_reg, mulx_g_reg, muly_g_reg;
    lane_flags_t       flx_reg;
    logic [1:0]        fly_reg;
    logic [31:0]       data_reg;
    logic              user_reg;

    // Hold everything while the output transfer is stalled
    assign en        = !vo_reg || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    // Deadzone register and its square
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dz_reg    <= '0;
            dz_sq_reg <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                dz_reg <= cfg_data;
            end
            dz_sq_reg <= dz_reg * dz_reg;
        end
    end

    // Valid bits travel with the data
    logic sq_valid, d1_valid, dx_valid, dy_valid;
    logic [RW-1:0] root;
    logic [SQ_W:0] sq_tag;
    logic [RW+SQ_W+1:0] d1_tag;
    logic [QW1-1:0] s_val;
    logic [QW2-1:0] qx, qy;
    lane_flags_t    dx_tag;
    logic [1:0]     dy_tag;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
            ve_reg <= 1'b0;
            vf_reg <= 1'b0;
            vg_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= s_tvalid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
            vd_reg <= sq_valid;
            ve_reg <= vd_reg;
            vf_reg <= d1_valid;
            vg_reg <= vf_reg;
            vo_reg <= dx_valid && dy_valid;
        end
    end

    // Capture, square, sum and deadzone test
    logic [MAG_W-1:0] magxa, magya;
    assign magxa = xa_reg[COORD_W-1] ? (MAG_W'(0) - {1'b1, xa_reg}) : {1'b0, xa_reg};
    assign magya = ya_reg[COORD_W-1] ? (MAG_W'(0) - {1'b1, ya_reg}) : {1'b0, ya_reg};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xa_reg     <= coord_t'(s_tdata[15:0]);
            ya_reg     <= coord_t'(s_tdata[31:16]);
            sqx_reg    <= SQ_W'(magxa * magxa);
            sqy_reg    <= SQ_W'(magya * magya);
            xb_reg     <= xa_reg;
            yb_reg     <= ya_reg;
            r2_reg     <= sqx_reg + sqy_reg;
            inside_reg <= (sqx_reg + sqy_reg) < SQ_W'(dz_sq_reg);
            xc_reg     <= xb_reg;
            yc_reg     <= yb_reg;
        end
    end

    tdrs_sqrt #(
        .RW (RW),
        .TW (SQ_W + 1)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vc_reg),
        .rad       ((2*RW)'(r2_reg) << (2*F)),
        .in_tag    ({xc_reg, yc_reg, inside_reg}),
        .out_valid (sq_valid),
        .root      (root),
        .out_tag   (sq_tag)
    );

    // Clamp radius, subtract deadzone, then scale numerator
    logic [RW-1:0] rc, dfix;
    assign rc   = (root > MAXFIX) ? MAXFIX : root;
    assign dfix = RW'(dz_reg) << F;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            diff_reg   <= (rc > dfix) ? QW1'(rc - dfix) : '0;
            rd_reg     <= root;
            xd_reg     <= sq_tag[SQ_W:COORD_W+1];
            yd_reg     <= sq_tag[COORD_W:1];
            ins_d_reg  <= sq_tag[0];
            zero_d_reg <= sq_tag[0] || (root == '0) || (dz_reg == STICK_MAX);
            num1_reg   <= N1W'(diff_reg) * N1W'(STICK_MAX);
            re_reg     <= rd_reg;
            xe_reg     <= xd_reg;
            ye_reg     <= yd_reg;
            ins_e_reg  <= ins_d_reg;
            zero_e_reg <= zero_d_reg;
        end
    end

    tdrs_div #(
        .NW (N1W),
        .DW (DZ_W),
        .QW (QW1),
        .TW (RW + SQ_W + 2)
    ) u_div_span (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (ve_reg),
        .num       (num1_reg),
        .den       (STICK_MAX - dz_reg),
        .in_tag    ({re_reg, xe_reg, ye_reg, ins_e_reg, zero_e_reg}),
        .out_valid (d1_valid),
        .quot      (s_val),
        .out_tag   (d1_tag)
    );

    // Direction products and overflow test against 32768 * radius
    coord_t           xt, yt;
    logic [MAG_W-1:0] magxt, magyt;
    assign xt    = d1_tag[SQ_W+1:COORD_W+2];
    assign yt    = d1_tag[COORD_W+1:2];
    assign magxt = xt[COORD_W-1] ? (MAG_W'(0) - {1'b1, xt}) : {1'b0, xt};
    assign magyt = yt[COORD_W-1] ? (MAG_W'(0) - {1'b1, yt}) : {1'b0, yt};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mulx_reg    <= N2W'(magxt) * N2W'(s_val);
            muly_reg    <= N2W'(magyt) * N2W'(s_val);
            rf_reg      <= d1_tag[RW+SQ_W+1:SQ_W+2];
            xf_reg      <= xt;
            yf_reg      <= yt;
            ins_f_reg   <= d1_tag[1];
            zero_f_reg  <= d1_tag[0];
            mulx_g_reg  <= mulx_reg;
            muly_g_reg  <= muly_reg;
            flx_reg.in_dz  <= ins_f_reg;
            flx_reg.zero   <= zero_f_reg;
            flx_reg.neg    <= xf_reg[COORD_W-1];
            flx_reg.ovf    <= (mulx_reg >> QW2) >= N2W'(rf_reg);
            fly_reg        <= {yf_reg[COORD_W-1], (muly_reg >> QW2) >= N2W'(rf_reg)};
        end
    end

    logic [RW-1:0] rg_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rg_reg <= rf_reg;
        end
    end

    tdrs_div #(
        .NW (N2W),
        .DW (RW),
        .QW (QW2),
        .TW (4)
    ) u_div_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vg_reg),
        .num       (mulx_g_reg),
        .den       (rg_reg),
        .in_tag    (flx_reg),
        .out_valid (dx_valid),
        .quot      (qx),
        .out_tag   (dx_tag)
    );

    tdrs_div #(
        .NW (N2W),
        .DW (RW),
        .QW (QW2),
        .TW (2)
    ) u_div_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vg_reg),
        .num       (muly_g_reg),
        .den       (rg_reg),
        .in_tag    (fly_reg),
        .out_valid (dy_valid),
        .quot      (qy),
        .out_tag   (dy_tag)
    );

    // Saturate, restore sign, force zero; output register
    logic [QW2-1:0] mx, my;
    logic [15:0]    ox, oy;
    assign mx = dx_tag.ovf ? STICK_MAX : qx;
    assign my = dy_tag[0]  ? STICK_MAX : qy;
    assign ox = dx_tag.zero ? '0 : (dx_tag.neg ? (16'd0 - {1'b0, mx}) : {1'b0, mx});
    assign oy = dx_tag.zero ? '0 : (dy_tag[1]  ? (16'd0 - {1'b0, my}) : {1'b0, my});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= {oy, ox};
            user_reg <= dx_tag.in_dz;
        end
    end

    assign m_tvalid   = vo_reg;
    assign m_tdata    = data_reg;
    assign m_tuser[0] = user_reg;

endmodule

@@ design/tdrs_checker.sv @@
module tdrs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [0:0]  m_tuser
);

    import tdrs_pkg::*;

    // Deadzone results carry zero coordinates
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
        else $error("deadzone result with nonzero coordinates");

    // Magnitudes never exceed the stick maximum
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[15:0] != 16'h8000 && m_tdata[31:16] != 16'h8000)
        else $error("scaled coordinate out of range");

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // Outside the deadzone, an x coordinate of zero differs from STICK_MAX + 1
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] && m_tdata[15:0] == 16'h0000 |->
        m_tdata[15:0] != {1'b0, STICK_MAX} + 16'd1)
        else $error("unexpected x value");

endmodule

bind thumbstick_radial_deadzone_scaler tdrs_checker u_tdrs_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
